// ===== rtl/fis_pkg.sv =====
// ----------------------------------------------------------------------------
// fis_pkg
// Shared types, codes and helpers for the frame index slot tracker.
// ----------------------------------------------------------------------------
package fis_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // wide enough for an 8-bit frame index and for SLOT_COUNT itself
  localparam int CMP_W      = 9;

  localparam logic [15:0] FRAME_TYPE_RST = 16'h88A4;

  // opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_TX    = 2'd2;
  localparam logic [1:0] OP_POLL  = 2'd3;

  // slot status codes (5..7 may be stored by a set request)
  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_SENT  = 3'd2;
  localparam logic [2:0] ST_RCVD  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // result codes
  localparam logic [1:0] RC_DONE  = 2'd0;
  localparam logic [1:0] RC_FOUND = 2'd1;
  localparam logic [1:0] RC_OTHER = 2'd2;
  localparam logic [1:0] RC_NONE  = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_A_RD,
    S_A_CHK,
    S_P_RD,
    S_P_CHK,
    S_P_PARK,
    S_OUT
  } fsm_t;

  typedef enum logic [1:0] {
    RD_REQ,
    RD_PTR,
    RD_FIDX
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    logic    search_adv;
    logic    claim;
    logic    set_wr;
    logic    tx_wr;
    logic    poll_eval;
    logic    park_eval;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       probe_empty;
    logic       turn_done;
    logic       need_park;
    logic       out_busy;
  } sts_t;

  function automatic slot_t slot_inc(input slot_t s);
    slot_inc = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

// ===== rtl/fis_if.sv =====
// ----------------------------------------------------------------------------
// fis_if
// Request and result channel interfaces (valid/ready) of the slot tracker.
// ----------------------------------------------------------------------------
interface fis_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  request_index;
  logic [2:0]  new_status;
  logic        frame_present;
  logic [15:0] frame_ethertype;
  logic [7:0]  frame_index;
  logic [15:0] frame_counter;

  modport source (
    output valid, opcode, request_index, new_status, frame_present,
           frame_ethertype, frame_index, frame_counter,
    input  ready
  );
  modport sink (
    input  valid, opcode, request_index, new_status, frame_present,
           frame_ethertype, frame_index, frame_counter,
    output ready
  );
endinterface

interface fis_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [3:0]  slot_index;
  logic [15:0] work_counter;

  modport source (
    output valid, result_code, slot_index, work_counter,
    input  ready
  );
  modport sink (
    input  valid, result_code, slot_index, work_counter,
    output ready
  );
endinterface

// ===== rtl/fis_ram.sv =====
// ----------------------------------------------------------------------------
// fis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fis_ctrl.sv =====
// ----------------------------------------------------------------------------
// fis_ctrl
// Sequencer: steps each request through slot search, poll or status write.
// ----------------------------------------------------------------------------
module fis_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_opcode,
  output logic          in_ready,
  input  fis_pkg::sts_t sts,
  output fis_pkg::cmd_t cmd
);
  import fis_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_REQ;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // dispatch on the incoming opcode; op_r is loaded on this edge
          case (in_opcode)
            OP_ALLOC: state_nxt = S_A_RD;
            OP_POLL:  state_nxt = S_P_RD;
            default:  state_nxt = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        if (sts.opcode == OP_SET) begin
          cmd.set_wr = 1'b1;
        end else begin
          cmd.tx_wr = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_A_RD: begin
        cmd.rd_sel = RD_PTR;
        state_nxt  = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.probe_empty || sts.turn_done) begin
          cmd.claim = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.search_adv = 1'b1;
          state_nxt      = S_A_RD;
        end
      end
      S_P_RD: begin
        cmd.rd_sel = RD_REQ;
        state_nxt  = S_P_CHK;
      end
      S_P_CHK: begin
        cmd.poll_eval = 1'b1;
        cmd.rd_sel    = RD_FIDX;
        state_nxt     = sts.need_park ? S_P_PARK : S_OUT;
      end
      S_P_PARK: begin
        cmd.park_eval = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/fis_dp.sv =====
// ----------------------------------------------------------------------------
// fis_dp
// Datapath: request registers, status and counter stores, result register.
// ----------------------------------------------------------------------------
module fis_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  fis_pkg::cmd_t cmd,
  output fis_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic [1:0]    opcode,
  input  logic [3:0]    request_index,
  input  logic [2:0]    new_status,
  input  logic          frame_present,
  input  logic [15:0]   frame_ethertype,
  input  logic [7:0]    frame_index,
  input  logic [15:0]   frame_counter,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    result_code,
  output logic [3:0]    slot_index,
  output logic [15:0]   work_counter
);
  import fis_pkg::*;

  // latched request
  logic [1:0]  op_r;
  logic [3:0]  req_r;
  logic [2:0]  nst_r;
  logic        present_r;
  logic [15:0] etype_r;
  logic [7:0]  fidx_r;
  logic [15:0] fcnt_r;

  logic [15:0] match_r;
  slot_t       last_r;
  slot_t       ptr_r, ptr_nxt;
  slot_t       start_r;
  slot_t       cnt_r;

  logic [SLOT_COUNT-1:0] vld_r;
  logic                  vld_q_r;

  logic [1:0]  res_code_r, res_code_nxt;
  logic [3:0]  res_slot_r;
  logic [15:0] res_wkc_r, res_wkc_nxt;

  logic        out_valid_r;
  logic [1:0]  out_code_r;
  logic [3:0]  out_slot_r;
  logic [15:0] out_wkc_r;

  // store ports
  logic        st_we;
  slot_t       st_waddr;
  logic [2:0]  st_wdata;
  slot_t       st_raddr;
  logic [2:0]  st_q;
  logic [2:0]  st_eff;
  logic        ctr_we;
  logic [15:0] ctr_q;

  slot_t       req_a, fidx_a, claim_slot;
  logic        req_in, fidx_in, type_ok, idx_hit;

  assign req_a      = SLOT_W'(req_r);
  assign fidx_a     = SLOT_W'(fidx_r);
  assign req_in     = CMP_W'(req_r) < CMP_W'(SLOT_COUNT);
  assign fidx_in    = CMP_W'(fidx_r) < CMP_W'(SLOT_COUNT);
  assign type_ok    = (etype_r == match_r);
  assign idx_hit    = (CMP_W'(fidx_r) == CMP_W'(req_r));
  // a slot never written reads as empty
  assign st_eff     = vld_q_r ? st_q : ST_EMPTY;
  assign claim_slot = (st_eff == ST_EMPTY) ? ptr_r : start_r;
  assign ptr_nxt    = slot_inc(ptr_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:  st_raddr = ptr_r;
      RD_FIDX: st_raddr = fidx_a;
      default: st_raddr = req_a;
    endcase
  end

  // status writes and poll evaluation
  always_comb begin
    st_we        = 1'b0;
    st_waddr     = req_a;
    st_wdata     = ST_EMPTY;
    ctr_we       = 1'b0;
    res_code_nxt = res_code_r;
    res_wkc_nxt  = res_wkc_r;
    if (cmd.load) begin
      res_code_nxt = RC_DONE;
      res_wkc_nxt  = '0;
    end
    if (cmd.claim) begin
      st_we    = 1'b1;
      st_waddr = claim_slot;
      st_wdata = ST_ALLOC;
    end
    if (cmd.set_wr) begin
      st_we    = req_in;
      st_wdata = nst_r;
    end
    if (cmd.tx_wr) begin
      st_we    = req_in;
      st_wdata = ST_SENT;
    end
    if (cmd.poll_eval) begin
      if (req_in && st_eff == ST_RCVD) begin
        res_code_nxt = RC_FOUND;
        res_wkc_nxt  = ctr_q;
        st_we        = 1'b1;
        st_wdata     = ST_DONE;
      end else if (!present_r) begin
        res_code_nxt = RC_NONE;
      end else begin
        res_code_nxt = RC_OTHER;
        if (type_ok && idx_hit) begin
          res_code_nxt = RC_FOUND;
          res_wkc_nxt  = fcnt_r;
          st_we        = req_in;
          st_wdata     = ST_DONE;
        end
      end
    end
    if (cmd.park_eval && st_eff == ST_SENT) begin
      st_we    = 1'b1;
      st_waddr = fidx_a;
      st_wdata = ST_RCVD;
      ctr_we   = 1'b1;
    end
  end

  // frame for another slot: look that slot up next
  assign sts.need_park = !(req_in && st_eff == ST_RCVD) && present_r && type_ok &&
                         !idx_hit && fidx_in;
  assign sts.opcode      = op_r;
  assign sts.probe_empty = (st_eff == ST_EMPTY);
  assign sts.turn_done   = (cnt_r == SLOT_W'(SLOT_COUNT - 1));
  assign sts.out_busy    = out_valid_r && !out_ready;

  fis_ram #(.WIDTH(3), .DEPTH(SLOT_COUNT)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_q)
  );

  fis_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_counter_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (fidx_a),
    .wdata (fcnt_r),
    .raddr (req_a),
    .rdata (ctr_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= FRAME_TYPE_RST;
      last_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        match_r <= cfg_wdata;
      end
      if (cmd.claim) begin
        last_r <= claim_slot;
      end
      if (st_we) begin
        vld_r[st_waddr] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    vld_q_r    <= vld_r[st_raddr];
    res_code_r <= res_code_nxt;
    res_wkc_r  <= res_wkc_nxt;
    if (cmd.load) begin
      op_r       <= opcode;
      req_r      <= request_index;
      nst_r      <= new_status;
      present_r  <= frame_present;
      etype_r    <= frame_ethertype;
      fidx_r     <= frame_index;
      fcnt_r     <= frame_counter;
      ptr_r      <= slot_inc(last_r);
      start_r    <= slot_inc(last_r);
      cnt_r      <= '0;
      res_slot_r <= request_index;
    end
    if (cmd.search_adv) begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.claim) begin
      res_slot_r <= 4'(claim_slot);
    end
    if (cmd.out_load) begin
      out_code_r <= res_code_r;
      out_slot_r <= res_slot_r;
      out_wkc_r  <= res_wkc_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign result_code  = out_code_r;
  assign slot_index   = out_slot_r;
  assign work_counter = out_wkc_r;

endmodule

// ===== rtl/frame_index_slot_tracker_top.sv =====
// ----------------------------------------------------------------------------
// frame_index_slot_tracker_top
// Datagram index slot tracker: allocate, status writes and frame polling.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one request per valid/ready transfer (opcode, index, status,
//              and for a poll the received frame's ethertype/index/counter).
//   out_chan : exactly one result per request, in request order.
//   cfg_we / cfg_wdata : write the ethertype to match; write only when idle.
// Steps per request, between accept and result:
//   set status / transmitted : status write
//   poll                     : read + check; park if another slot's frame
//   allocate                 : N probes, N = slots probed (1..SLOT_COUNT);
//                              each probe is one status RAM read + check.
//   The status store has a single read port; the round-robin search reads
//   one slot per probe.
// Results leave through the output register. A finished result
// waits in the output register; the next request is still accepted and runs
// until it too must hand over a result, then holds until out_chan.ready.
// Reset (rst_n low, synchronous): all slots read as empty (valid bits clear,
// no clearing pass), last slot = 0, match ethertype = 0x88A4, output empty.
// ----------------------------------------------------------------------------
module frame_index_slot_tracker_top (
  input  logic         clk,
  input  logic         rst_n,
  fis_in_if.sink       in_chan,
  fis_out_if.source    out_chan,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import fis_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: owns the request handshake
  fis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign in_chan.ready = in_ready;

  // datapath: stores, search pointer, result and output register
  fis_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .opcode          (in_chan.opcode),
    .request_index   (in_chan.request_index),
    .new_status      (in_chan.new_status),
    .frame_present   (in_chan.frame_present),
    .frame_ethertype (in_chan.frame_ethertype),
    .frame_index     (in_chan.frame_index),
    .frame_counter   (in_chan.frame_counter),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .result_code     (out_chan.result_code),
    .slot_index      (out_chan.slot_index),
    .work_counter    (out_chan.work_counter)
  );

endmodule

// ===== rtl/fis_checker.sv =====
// ----------------------------------------------------------------------------
// fis_checker
// Port-level assertions for the slot tracker, bound to the top level.
// ----------------------------------------------------------------------------
module fis_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_code,
  input logic [3:0]  slot_index,
  input logic [15:0] work_counter
);
  import fis_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_code) &&
    $stable(slot_index) && $stable(work_counter))
    else $error("result changed while stalled");

  // one request at a time: no accept on the cycle after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // counter only reported with a found frame
  a_wkc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_code != RC_FOUND |-> work_counter == 16'd0)
    else $error("working counter without found frame");

  // reset empties the output
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_index_slot_tracker_top fis_checker u_fis_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .result_code  (out_chan.result_code),
  .slot_index   (out_chan.slot_index),
  .work_counter (out_chan.work_counter)
);
